// File: sv/qslerp_pkg.sv
// Shared constants, the CORDIC arctangent table and the types that travel down the pipeline.
package qslerp_pkg;

  // Iteration counts of the CORDIC units, the square root and the divider, and the divider's fraction bits.
  localparam int ITERS     = 30;
  localparam int SQRT_BITS = 31;
  localparam int DIV_STEPS = 34;
  localparam int DIV_FRAC  = 30;

  // Fixed-point units: one in Q0.16 and in Q1.15.
  localparam logic [16:0]        ONE16 = 17'd65536;
  localparam logic signed [20:0] ONE15 = 21'sd32768;

  // Start value of the rotating CORDIC, the inverse of its gain in Q1.30.
  localparam logic signed [33:0] GAIN_INV = 34'sd652032874;

  // atan(2^-i) in Q2.30 radians, truncated.
  localparam logic signed [33:0] ATAN_TAB [ITERS] = '{
    34'sh3243F6A8, 34'sh1DAC6705, 34'sh0FADBAFC, 34'sh07F56EA6, 34'sh03FEAB76,
    34'sh01FFD55B, 34'sh00FFFAAA, 34'sh007FFF55, 34'sh003FFFEA, 34'sh001FFFFD,
    34'sh000FFFFF, 34'sh0007FFFF, 34'sh0003FFFF, 34'sh0001FFFF, 34'sh0000FFFF,
    34'sh00007FFF, 34'sh00003FFF, 34'sh00001FFF, 34'sh00000FFF, 34'sh000007FF,
    34'sh000003FF, 34'sh000001FF, 34'sh000000FF, 34'sh0000007F, 34'sh0000003F,
    34'sh0000001F, 34'sh0000000F, 34'sh00000008, 34'sh00000004, 34'sh00000002
  };

  // Register map and reset value of the tolerance register.
  localparam logic [0:0]  ADDR_EQUAL_TOL = 1'b0;
  localparam logic [12:0] TOL_RESET      = 13'd4;

  // How the final weights of an item are chosen.
  typedef enum logic [1:0] {
    WSEL_FIRST,
    WSEL_SECOND,
    WSEL_LINEAR,
    WSEL_ARC
  } wsel_t;

  // Item data that rides alongside the arithmetic units.
  typedef struct packed {
    logic [3:0][15:0] qa;
    logic [3:0][16:0] qb;
    logic [16:0]      t;
    logic [15:0]      c15;
    wsel_t            wsel;
  } side_t;

endpackage

// File: sv/qslerp_if.sv
// Valid/ready channel interfaces for the input pair of quaternions and the blended result.
interface qslerp_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] first_x;
  logic signed [15:0] first_y;
  logic signed [15:0] first_z;
  logic signed [15:0] first_w;
  logic signed [15:0] second_x;
  logic signed [15:0] second_y;
  logic signed [15:0] second_z;
  logic signed [15:0] second_w;
  logic [16:0]        blend;

  modport source (
    output valid, first_x, first_y, first_z, first_w,
    output second_x, second_y, second_z, second_w, blend,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, first_z, first_w,
    input  second_x, second_y, second_z, second_w, blend,
    output ready
  );
endinterface

interface qslerp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_z;
  logic signed [15:0] out_w;

  modport source (output valid, out_x, out_y, out_z, out_w, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, output ready);
endinterface

// File: sv/qslerp_isqrt.sv
// Pipelined floor square root, one result bit per stage.
module qslerp_isqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [60:0]         rad,
  input  qslerp_pkg::side_t   in_side,
  output logic                out_valid,
  output logic [30:0]         root,
  output qslerp_pkg::side_t   out_side
);
  import qslerp_pkg::*;

  logic [61:0] rem_r  [SQRT_BITS];
  logic [30:0] q_r    [SQRT_BITS];
  side_t       side_r [SQRT_BITS];
  logic        v_r    [SQRT_BITS];

  for (genvar k = 0; k < SQRT_BITS; k++) begin : g_stage
    localparam int J = SQRT_BITS - 1 - k;
    logic [61:0] rem_i;
    logic [61:0] trial;
    logic [30:0] q_i;
    side_t       side_i;
    logic        v_i;

    if (k == 0) begin : g_first
      assign rem_i  = {1'b0, rad};
      assign q_i    = '0;
      assign side_i = in_side;
      assign v_i    = in_valid;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign q_i    = q_r[k-1];
      assign side_i = side_r[k-1];
      assign v_i    = v_r[k-1];
    end

    // Cost of setting bit J: (q + 2^J)^2 - q^2.
    assign trial = ({31'b0, q_i} << (J + 1)) + (62'd1 << (2 * J));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    // Keep the bit when the remainder still covers its cost.
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_i >= trial) begin
          rem_r[k] <= rem_i - trial;
          q_r[k]   <= q_i | (31'd1 << J);
        end else begin
          rem_r[k] <= rem_i;
          q_r[k]   <= q_i;
        end
        side_r[k] <= side_i;
      end
    end
  end

  assign out_valid = v_r[SQRT_BITS-1];
  assign root      = q_r[SQRT_BITS-1];
  assign out_side  = side_r[SQRT_BITS-1];

endmodule

// File: sv/qslerp_vec.sv
// Pipelined CORDIC in vectoring mode: the angle of (x, y), one iteration per stage.
module qslerp_vec (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [33:0]  x_in,
  input  logic signed [33:0]  y_in,
  input  qslerp_pkg::side_t   in_side,
  output logic                out_valid,
  output logic signed [33:0]  angle,
  output qslerp_pkg::side_t   out_side
);
  import qslerp_pkg::*;

  logic signed [33:0] x_r    [ITERS];
  logic signed [33:0] y_r    [ITERS];
  logic signed [33:0] z_r    [ITERS];
  side_t              side_r [ITERS];
  logic               v_r    [ITERS];

  for (genvar k = 0; k < ITERS; k++) begin : g_iter
    logic signed [33:0] x_i;
    logic signed [33:0] y_i;
    logic signed [33:0] z_i;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    side_t              side_i;
    logic               v_i;

    if (k == 0) begin : g_first
      assign x_i    = x_in;
      assign y_i    = y_in;
      assign z_i    = '0;
      assign side_i = in_side;
      assign v_i    = in_valid;
    end else begin : g_next
      assign x_i    = x_r[k-1];
      assign y_i    = y_r[k-1];
      assign z_i    = z_r[k-1];
      assign side_i = side_r[k-1];
      assign v_i    = v_r[k-1];
    end

    assign dx = y_i >>> k;
    assign dy = x_i >>> k;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    // Rotate towards the x axis and accumulate the angle turned.
    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_i[33]) begin
          x_r[k] <= x_i + dx;
          y_r[k] <= y_i - dy;
          z_r[k] <= z_i + ATAN_TAB[k];
        end else begin
          x_r[k] <= x_i - dx;
          y_r[k] <= y_i + dy;
          z_r[k] <= z_i - ATAN_TAB[k];
        end
        side_r[k] <= side_i;
      end
    end
  end

  assign out_valid = v_r[ITERS-1];
  assign angle     = z_r[ITERS-1];
  assign out_side  = side_r[ITERS-1];

endmodule

// File: sv/qslerp_sin3.sv
// Three-lane pipelined CORDIC in rotation mode giving the sines of three angles.
module qslerp_sin3 (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [33:0]  z_in [3],
  input  qslerp_pkg::side_t   in_side,
  output logic                out_valid,
  output logic signed [33:0]  sin_out [3],
  output qslerp_pkg::side_t   out_side
);
  import qslerp_pkg::*;

  logic signed [33:0] x_r    [ITERS][3];
  logic signed [33:0] y_r    [ITERS][3];
  logic signed [33:0] z_r    [ITERS][3];
  side_t              side_r [ITERS];
  logic               v_r    [ITERS];

  for (genvar k = 0; k < ITERS; k++) begin : g_iter
    side_t side_i;
    logic  v_i;

    if (k == 0) begin : g_first
      assign side_i = in_side;
      assign v_i    = in_valid;
    end else begin : g_next
      assign side_i = side_r[k-1];
      assign v_i    = v_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_i;
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic signed [33:0] x_i;
      logic signed [33:0] y_i;
      logic signed [33:0] z_i;
      logic signed [33:0] dx;
      logic signed [33:0] dy;

      if (k == 0) begin : g_first
        assign x_i = GAIN_INV;
        assign y_i = '0;
        assign z_i = z_in[l];
      end else begin : g_next
        assign x_i = x_r[k-1][l];
        assign y_i = y_r[k-1][l];
        assign z_i = z_r[k-1][l];
      end

      assign dx = y_i >>> k;
      assign dy = x_i >>> k;

      // Rotate the unit vector until the residual angle is used up.
      always_ff @(posedge clk) begin
        if (en) begin
          if (!z_i[33]) begin
            x_r[k][l] <= x_i - dx;
            y_r[k][l] <= y_i + dy;
            z_r[k][l] <= z_i - ATAN_TAB[k];
          end else begin
            x_r[k][l] <= x_i + dx;
            y_r[k][l] <= y_i - dy;
            z_r[k][l] <= z_i + ATAN_TAB[k];
          end
        end
      end
    end
  end

  // The sine of each lane is the y value of the last iteration.
  for (genvar l = 0; l < 3; l++) begin : g_out
    assign sin_out[l] = y_r[ITERS-1][l];
  end

  assign out_valid = v_r[ITERS-1];
  assign out_side  = side_r[ITERS-1];

endmodule

// File: sv/qslerp_div.sv
// Two-lane pipelined restoring divider for the weights: floor(num * 2^30 / den), limited to 2^32.
module qslerp_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [32:0]         num [2],
  input  logic [31:0]         den,
  input  qslerp_pkg::side_t   in_side,
  output logic                out_valid,
  output logic [32:0]         quo [2],
  output qslerp_pkg::side_t   out_side
);
  import qslerp_pkg::*;

  localparam logic [33:0] WEIGHT_MAX = 34'h1_0000_0000;

  logic [32:0] r_r    [DIV_STEPS][2];
  logic [33:0] q_r    [DIV_STEPS][2];
  logic        sat_r  [DIV_STEPS][2];
  logic [3:0]  nib_r  [DIV_STEPS][2];
  logic [31:0] den_r  [DIV_STEPS];
  side_t       side_r [DIV_STEPS];
  logic        v_r    [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    localparam int P = DIV_STEPS - 1 - k;
    logic [31:0] den_i;
    side_t       side_i;
    logic        v_i;

    if (k == 0) begin : g_first
      assign den_i  = den;
      assign side_i = in_side;
      assign v_i    = in_valid;
    end else begin : g_next
      assign den_i  = den_r[k-1];
      assign side_i = side_r[k-1];
      assign v_i    = v_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k]  <= den_i;
        side_r[k] <= side_i;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [32:0] r_i;
      logic [32:0] r_sh;
      logic [33:0] q_i;
      logic        sat_i;
      logic [3:0]  nib_i;
      logic        dbit;

      // The first stage starts from the top of the dividend and flags a
      // quotient of 2^34 or more, which the limit covers anyway.
      if (k == 0) begin : g_first
        assign r_i   = {4'b0, num[l][32:4]};
        assign q_i   = '0;
        assign sat_i = ({3'b0, num[l]} >= {den, 4'b0});
        assign nib_i = num[l][3:0];
      end else begin : g_next
        assign r_i   = r_r[k-1][l];
        assign q_i   = q_r[k-1][l];
        assign sat_i = sat_r[k-1][l];
        assign nib_i = nib_r[k-1][l];
      end

      // Dividend bits below 2^30 are zero.
      if (P >= DIV_FRAC) begin : g_num_bit
        assign dbit = nib_i[P-DIV_FRAC];
      end else begin : g_zero_bit
        assign dbit = 1'b0;
      end

      assign r_sh = {r_i[31:0], dbit};

      always_ff @(posedge clk) begin
        if (en) begin
          if (r_sh >= {1'b0, den_i}) begin
            r_r[k][l] <= r_sh - {1'b0, den_i};
            q_r[k][l] <= q_i | (34'd1 << P);
          end else begin
            r_r[k][l] <= r_sh;
            q_r[k][l] <= q_i;
          end
          sat_r[k][l] <= sat_i;
          nib_r[k][l] <= nib_i;
        end
      end
    end
  end

  // Limit the weight to 2^32.
  for (genvar l = 0; l < 2; l++) begin : g_limit
    always_comb begin
      if (sat_r[DIV_STEPS-1][l] || (q_r[DIV_STEPS-1][l] > WEIGHT_MAX)) begin
        quo[l] = WEIGHT_MAX[32:0];
      end else begin
        quo[l] = q_r[DIV_STEPS-1][l][32:0];
      end
    end
  end

  assign out_valid = v_r[DIV_STEPS-1];
  assign out_side  = side_r[DIV_STEPS-1];

endmodule

// File: sv/quaternion_slerp.sv
// Spherical linear interpolation of two Q1.15 quaternions by a Q0.16 fraction, fully pipelined.
// The block accepts one item per clock while the result channel does not stall, and returns the
// results in order. The pipeline runs through the dot product, rounding and case selection, the
// square root that gives sin(theta), the vectoring CORDIC that gives theta, the product theta*t,
// the three parallel sine CORDICs, the two weight dividers and the final multiply, rounding and
// saturation. When the result channel stalls, the whole pipeline holds, so input ready follows
// output ready while the last stage is full. The tolerance register (byte address 0, 13 bits,
// reset 4) should only be written while no item is in flight.
module quaternion_slerp (
  input  logic          clk,
  input  logic          rst_n,
  qslerp_in_if.sink     in_ch,
  qslerp_out_if.source  out_ch,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [0:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import qslerp_pkg::*;

  logic [12:0] tol_r;
  logic        en;

  // Stage valid bits.
  logic v1_r, v2_r, v3_r, v4_r, vm_r, vf_r, out_valid_r;

  logic signed [15:0] in_a [4];
  logic signed [15:0] in_b [4];

  // Stage 1: operands and component products.
  logic [3:0][15:0]   qa1_r;
  logic [3:0][16:0]   qb1_r;
  logic [16:0]        t1_r;
  logic signed [31:0] p1_r [4];

  // Stage 2: dot product and early outs on t.
  logic [3:0][15:0]   qa2_r;
  logic [3:0][16:0]   qb2_r;
  logic [16:0]        t2_r;
  logic signed [33:0] dot2_r;
  wsel_t              wsel2_r;
  wsel_t              wsel2_nxt;

  // Stage 3: rounded cosines.
  logic [3:0][15:0]   qa3_r;
  logic [3:0][16:0]   qb3_r;
  logic [16:0]        t3_r;
  logic signed [19:0] cs3_r;
  logic [15:0]        c3_r;
  logic               neg3_r;
  wsel_t              wsel3_r;
  logic signed [33:0] cs_sum;
  logic signed [33:0] dabs;
  logic signed [33:0] dabs_sum;
  logic [18:0]        c_raw;
  logic [15:0]        c_nxt;

  // Stage 4: case decision, arc flip and cos^2.
  side_t              side4_r;
  side_t              side4_nxt;
  logic [30:0]        sq4_r;
  logic signed [20:0] diff;
  logic signed [20:0] diff_abs;
  logic [60:0]        rad;

  // Square root and vectoring CORDIC.
  logic               isq_valid;
  logic [30:0]        root;
  side_t              isq_side;
  logic signed [33:0] vec_x;
  logic signed [33:0] vec_y;
  logic               vec_valid;
  logic signed [33:0] theta_z;
  side_t              vec_side;

  // Angle split stage.
  logic [30:0]        thm_nxt;
  logic [30:0]        thm_r;
  logic [47:0]        prodm_r;
  side_t              sidem_r;
  logic [30:0]        a1w;
  logic signed [33:0] z_sin [3];

  // Sines and weights.
  logic               sin_valid;
  logic signed [33:0] sy [3];
  side_t              sin_side;
  logic               sd_ok;
  logic [31:0]        div_den;
  logic [32:0]        div_num [2];
  side_t              div_side_in;
  logic               div_valid;
  logic [32:0]        quo [2];
  side_t              div_side;

  // Final stages.
  logic [32:0]        k0;
  logic [32:0]        k1;
  logic signed [49:0] pa_nxt [4];
  logic signed [50:0] pb_nxt [4];
  logic signed [49:0] pa_r [4];
  logic signed [50:0] pb_r [4];
  logic signed [52:0] sum;
  logic signed [22:0] vsh;
  logic signed [15:0] res_nxt [4];
  logic signed [15:0] res_r [4];

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_EQUAL_TOL) ? {19'b0, tol_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (psel && penable && pwrite && (paddr == ADDR_EQUAL_TOL)) begin
      tol_r <= pwdata[12:0];
    end
  end

  // The pipeline moves whenever the output register is free or being emptied.
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  assign in_a[0] = in_ch.first_x;
  assign in_a[1] = in_ch.first_y;
  assign in_a[2] = in_ch.first_z;
  assign in_a[3] = in_ch.first_w;
  assign in_b[0] = in_ch.second_x;
  assign in_b[1] = in_ch.second_y;
  assign in_b[2] = in_ch.second_z;
  assign in_b[3] = in_ch.second_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      vm_r        <= 1'b0;
      vf_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_ch.valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      vm_r        <= vec_valid;
      vf_r        <= div_valid;
      out_valid_r <= vf_r;
    end
  end

  // Stage 1: capture the item, clamp t to one and form the component products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        qa1_r[i] <= in_a[i];
        qb1_r[i] <= {in_b[i][15], in_b[i]};
        p1_r[i]  <= in_a[i] * in_b[i];
      end
      t1_r <= (in_ch.blend > ONE16) ? ONE16 : in_ch.blend;
    end
  end

  // Stage 2: sum the dot product and pick out t near zero or near one.
  always_comb begin
    if (t1_r <= {4'b0, tol_r}) begin
      wsel2_nxt = WSEL_FIRST;
    end else if ((ONE16 - t1_r) <= {4'b0, tol_r}) begin
      wsel2_nxt = WSEL_SECOND;
    end else begin
      wsel2_nxt = WSEL_ARC;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qa2_r   <= qa1_r;
      qb2_r   <= qb1_r;
      t2_r    <= t1_r;
      dot2_r  <= 34'(p1_r[0]) + 34'(p1_r[1]) + 34'(p1_r[2]) + 34'(p1_r[3]);
      wsel2_r <= wsel2_nxt;
    end
  end

  // Stage 3: round the signed dot product and its magnitude to Q1.15.
  always_comb begin
    cs_sum   = dot2_r + 34'sd16384;
    dabs     = dot2_r[33] ? -dot2_r : dot2_r;
    dabs_sum = dabs + 34'sd16384;
    c_raw    = dabs_sum[33:15];
    c_nxt    = (c_raw > 19'd32768) ? 16'd32768 : c_raw[15:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qa3_r   <= qa2_r;
      qb3_r   <= qb2_r;
      t3_r    <= t2_r;
      cs3_r   <= {cs_sum[33], cs_sum[33:15]};
      c3_r    <= c_nxt;
      neg3_r  <= dot2_r[33];
      wsel3_r <= wsel2_r;
    end
  end

  // Stage 4: near-parallel test, shorter-arc flip and the linear test.
  always_comb begin
    diff     = 21'(cs3_r) - ONE15;
    diff_abs = diff[20] ? -diff : diff;
    side4_nxt.qa   = qa3_r;
    side4_nxt.qb   = qb3_r;
    side4_nxt.t    = t3_r;
    side4_nxt.c15  = c3_r;
    side4_nxt.wsel = wsel3_r;
    if (wsel3_r == WSEL_ARC) begin
      if ($unsigned(diff_abs) <= {8'b0, tol_r}) begin
        side4_nxt.wsel = WSEL_SECOND;
      end else begin
        if (neg3_r) begin
          for (int i = 0; i < 4; i++) begin
            side4_nxt.qb[i] = -qb3_r[i];
          end
        end
        if ((17'd32768 - {1'b0, c3_r}) <= {4'b0, tol_r}) begin
          side4_nxt.wsel = WSEL_LINEAR;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4_r <= side4_nxt;
      sq4_r   <= {15'b0, c3_r} * {15'b0, c3_r};
    end
  end

  // sin(theta) = sqrt(2^60 - (cos * 2^15)^2).
  assign rad = {31'd1073741824 - sq4_r, 30'b0};

  qslerp_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v4_r),
    .rad       (rad),
    .in_side   (side4_r),
    .out_valid (isq_valid),
    .root      (root),
    .out_side  (isq_side)
  );

  assign vec_x = {3'b0, isq_side.c15, 15'b0};
  assign vec_y = {3'b0, root};

  qslerp_vec u_vec (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (isq_valid),
    .x_in      (vec_x),
    .y_in      (vec_y),
    .in_side   (isq_side),
    .out_valid (vec_valid),
    .angle     (theta_z),
    .out_side  (vec_side)
  );

  // Clamp theta at zero and scale it by t.
  assign thm_nxt = theta_z[33] ? 31'b0 : theta_z[30:0];

  always_ff @(posedge clk) begin
    if (en) begin
      thm_r   <= thm_nxt;
      prodm_r <= 48'(thm_nxt) * 48'(vec_side.t);
      sidem_r <= vec_side;
    end
  end

  // Angles for sin(theta), sin((1-t)theta) and sin(t theta).
  assign a1w      = prodm_r[46:16];
  assign z_sin[0] = {3'b0, thm_r};
  assign z_sin[1] = {3'b0, thm_r} - {3'b0, a1w};
  assign z_sin[2] = {3'b0, a1w};

  qslerp_sin3 u_sin3 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vm_r),
    .z_in      (z_sin),
    .in_side   (sidem_r),
    .out_valid (sin_valid),
    .sin_out   (sy),
    .out_side  (sin_side)
  );

  // A sine of theta that is not positive falls back to the linear weights.
  always_comb begin
    sd_ok      = (sy[0] > 34'sd0);
    div_den    = sd_ok ? sy[0][31:0] : 32'd1;
    div_num[0] = sy[1][33] ? 33'b0 : sy[1][32:0];
    div_num[1] = sy[2][33] ? 33'b0 : sy[2][32:0];
    div_side_in = sin_side;
    if (!sd_ok && (sin_side.wsel == WSEL_ARC)) begin
      div_side_in.wsel = WSEL_LINEAR;
    end
  end

  qslerp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sin_valid),
    .num       (div_num),
    .den       (div_den),
    .in_side   (div_side_in),
    .out_valid (div_valid),
    .quo       (quo),
    .out_side  (div_side)
  );

  // Final stage 1: choose the weights and multiply them into the components.
  always_comb begin
    case (div_side.wsel)
      WSEL_FIRST: begin
        k0 = 33'h0_4000_0000;
        k1 = 33'b0;
      end
      WSEL_SECOND: begin
        k0 = 33'b0;
        k1 = 33'h0_4000_0000;
      end
      WSEL_LINEAR: begin
        k0 = {2'b0, ONE16 - div_side.t, 14'b0};
        k1 = {2'b0, div_side.t, 14'b0};
      end
      WSEL_ARC: begin
        k0 = quo[0];
        k1 = quo[1];
      end
      default: begin
        k0 = 33'b0;
        k1 = 33'b0;
      end
    endcase
    for (int i = 0; i < 4; i++) begin
      pa_nxt[i] = $signed({1'b0, k0}) * $signed(div_side.qa[i]);
      pb_nxt[i] = $signed({1'b0, k1}) * $signed(div_side.qb[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
    end
  end

  // Final stage 2: add, round to Q1.15 and saturate.
  always_comb begin
    sum = '0;
    vsh = '0;
    for (int i = 0; i < 4; i++) begin
      sum = 53'(pa_r[i]) + 53'(pb_r[i]) + 53'sd536870912;
      vsh = sum[52:30];
      if (vsh > 23'sd32767) begin
        res_nxt[i] = 16'sh7FFF;
      end else if (vsh < -23'sd32768) begin
        res_nxt[i] = 16'sh8000;
      end else begin
        res_nxt[i] = vsh[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.out_x = res_r[0];
  assign out_ch.out_y = res_r[1];
  assign out_ch.out_z = res_r[2];
  assign out_ch.out_w = res_r[3];

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the fixed-point quaternion slerp pipeline.
`timescale 1ns / 1ps

module testbench;
  import qslerp_pkg::*;

  // One pair of quaternions with its blend fraction.
  typedef struct {
    logic signed [15:0] qa [4];
    logic signed [15:0] qb [4];
    logic [16:0]        blend;
  } pair_t;

  // One blended quaternion.
  typedef struct {
    logic signed [15:0] q [4];
  } quat_t;

  // Holds the tolerance and the queue of predicted blends, and checks each result.
  class slerp_scoreboard;
    quat_t       predicted [$];
    logic [12:0] tol;
    int          errors;

    function new();
      tol    = TOL_RESET;
      errors = 0;
    endfunction

    static function longint root_floor(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return longint'(r);
    endfunction

    // Vectoring CORDIC: angle of (x, y) in Q2.30 radians.
    static function longint arc_angle(longint x, longint y);
      longint z;
      longint dx;
      longint dy;
      z = 0;
      for (int i = 0; i < ITERS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx; y = y - dy; z = z + longint'(ATAN_TAB[i]);
        end else begin
          x = x - dx; y = y + dy; z = z - longint'(ATAN_TAB[i]);
        end
      end
      return z;
    endfunction

    // Rotating CORDIC: sine of a Q2.30 angle in Q1.30.
    static function longint arc_sine(longint z);
      longint x;
      longint y;
      longint dx;
      longint dy;
      x = longint'(GAIN_INV);
      y = 0;
      for (int i = 0; i < ITERS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx; y = y + dy; z = z - longint'(ATAN_TAB[i]);
        end else begin
          x = x + dx; y = y - dy; z = z + longint'(ATAN_TAB[i]);
        end
      end
      return y;
    endfunction

    static function longint sine_ratio(longint s, longint sd);
      longint k;
      if (s < 0) s = 0;
      if (s > (64'sd1 <<< 32)) s = 64'sd1 <<< 32;
      k = (s <<< 30) / sd;
      if (k > (64'sd1 <<< 32)) k = 64'sd1 <<< 32;
      return k;
    endfunction

    function quat_t blend_pair(pair_t p);
      quat_t  r;
      longint a [4];
      longint b [4];
      longint t;
      longint tl;
      longint dot;
      longint cs;
      longint diff;
      longint k0;
      longint k1;
      longint c30;
      longint s30;
      longint theta;
      longint a1;
      longint sd;
      longint v;
      bit     lin;
      tl = longint'(tol);
      for (int i = 0; i < 4; i++) begin
        a[i] = longint'(p.qa[i]);
        b[i] = longint'(p.qb[i]);
      end
      t = longint'(p.blend);
      if (t > 65536) t = 65536;
      // Blend close to zero or one passes an input through.
      if (t <= tl) begin
        foreach (r.q[i]) r.q[i] = p.qa[i];
        return r;
      end
      if (65536 - t <= tl) begin
        foreach (r.q[i]) r.q[i] = p.qb[i];
        return r;
      end
      dot = 0;
      for (int i = 0; i < 4; i++) dot = dot + a[i] * b[i];
      cs = (dot + 16384) >>> 15;
      diff = cs - 32768;
      if (diff < 0) diff = -diff;
      if (diff <= tl) begin
        foreach (r.q[i]) r.q[i] = p.qb[i];
        return r;
      end
      // Take the shorter arc.
      if (dot < 0) begin
        for (int i = 0; i < 4; i++) b[i] = -b[i];
        dot = -dot;
      end
      cs = (dot + 16384) >>> 15;
      if (cs > 32768) cs = 32768;
      lin = (32768 - cs) <= tl;
      k0 = 0;
      k1 = 0;
      if (!lin) begin
        c30 = cs <<< 15;
        s30 = root_floor((64'd1 << 60) - longint'(c30 * c30));
        theta = arc_angle(c30, s30);
        if (theta < 0) theta = 0;
        a1 = (theta * t) >>> 16;
        sd = arc_sine(theta);
        if (sd <= 0) begin
          lin = 1;
        end else begin
          k0 = sine_ratio(arc_sine(theta - a1), sd);
          k1 = sine_ratio(arc_sine(a1), sd);
        end
      end
      if (lin) begin
        k0 = (65536 - t) <<< 14;
        k1 = t <<< 14;
      end
      for (int i = 0; i < 4; i++) begin
        v = (k0 * a[i] + k1 * b[i] + (64'sd1 <<< 29)) >>> 30;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        r.q[i] = v[15:0];
      end
      return r;
    endfunction

    function void note_pair(pair_t p);
      predicted.push_back(blend_pair(p));
    endfunction

    function void check_blend(quat_t got);
      quat_t exp_q;
      if (predicted.size() == 0) begin
        $display("%0t: unexpected item (%0d %0d %0d %0d)", $time,
                 got.q[0], got.q[1], got.q[2], got.q[3]);
        errors++;
        return;
      end
      exp_q = predicted.pop_front();
      for (int i = 0; i < 4; i++) begin
        if (got.q[i] !== exp_q.q[i]) begin
          $display("%0t: component %0d expected %0d, got %0d", $time, i,
                   exp_q.q[i], got.q[i]);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [0:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  qslerp_in_if  in_ch ();
  qslerp_out_if out_ch ();

  quaternion_slerp uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch.sink),
    .out_ch  (out_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  slerp_scoreboard sb = new();
  bit calm;
  bit hold_req;
  int hold_cnt;
  int quiet_cycles;

  // Clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: checks every accepted result and stalls at random or for a long hold-off.
  always @(posedge clk) begin
    quat_t got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_cnt     <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.q[0] = out_ch.out_x;
        got.q[1] = out_ch.out_y;
        got.q[2] = out_ch.out_z;
        got.q[3] = out_ch.out_w;
        sb.check_blend(got);
      end
      if (hold_req && hold_cnt == 0) begin
        hold_cnt     <= 400;
        out_ch.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt     <= hold_cnt - 1;
        out_ch.ready <= (hold_cnt == 1);
      end else begin
        out_ch.ready <= calm || ($urandom_range(0, 99) >= 20);
      end
    end
  end

  // Watchdog on cycles with no item moving on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic offer_pair(pair_t p);
    int gap;
    in_ch.valid    <= 1'b1;
    in_ch.first_x  <= p.qa[0];
    in_ch.first_y  <= p.qa[1];
    in_ch.first_z  <= p.qa[2];
    in_ch.first_w  <= p.qa[3];
    in_ch.second_x <= p.qb[0];
    in_ch.second_y <= p.qb[1];
    in_ch.second_z <= p.qb[2];
    in_ch.second_w <= p.qb[3];
    in_ch.blend    <= p.blend;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_pair(p);
    if (!calm && $urandom_range(0, 99) < 10) begin
      gap = $urandom_range(1, 4);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits for every predicted blend, then lets the pipeline empty.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.predicted.size() != 0) @(posedge clk);
    repeat (140) @(posedge clk);
  endtask

  task automatic write_tol(logic [12:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= ADDR_EQUAL_TOL;
    pwdata  <= {19'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.tol = v;
  endtask

  task automatic read_tol();
    @(posedge clk);
    psel  <= 1'b1;
    paddr <= ADDR_EQUAL_TOL;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[12:0] !== sb.tol) begin
      $display("%0t: tolerance read expected %0d, got %0d", $time, sb.tol, prdata[12:0]);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // A random unit quaternion in Q1.15.
  function automatic void unit_quat(output logic signed [15:0] q [4]);
    real c [4];
    real n;
    n = 0.0;
    for (int i = 0; i < 4; i++) begin
      c[i] = real'($urandom_range(0, 20000)) - 10000.0;
      n = n + c[i] * c[i];
    end
    if (n < 1.0) begin
      c[3] = 1.0;
      n = 1.0;
    end
    n = $sqrt(n);
    for (int i = 0; i < 4; i++) q[i] = 16'($rtoi(c[i] / n * 32767.0));
  endfunction

  function automatic logic [16:0] random_blend();
    case ($urandom_range(0, 9))
      0:       return 17'($urandom_range(0, 40));
      1:       return 17'(65536 - $urandom_range(0, 40));
      2:       return 17'($urandom_range(65536, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    int    kind;
    int    sgn;
    kind = $urandom_range(0, 99);
    unit_quat(p.qa);
    if (kind < 50) begin
      unit_quat(p.qb);
    end else if (kind < 80) begin
      // Nearly parallel or nearly opposite pair.
      sgn = $urandom_range(0, 1) ? 1 : -1;
      for (int i = 0; i < 4; i++)
        p.qb[i] = 16'(sgn * p.qa[i] + $signed($urandom_range(0, 400)) - 200);
    end else begin
      for (int i = 0; i < 4; i++) begin
        p.qa[i] = 16'($urandom);
        p.qb[i] = 16'($urandom);
      end
    end
    p.blend = random_blend();
    return p;
  endfunction

  function automatic pair_t make_pair(int a0, int a1, int a2, int a3,
                                      int b0, int b1, int b2, int b3, int t);
    pair_t p;
    p.qa[0] = 16'(a0); p.qa[1] = 16'(a1); p.qa[2] = 16'(a2); p.qa[3] = 16'(a3);
    p.qb[0] = 16'(b0); p.qb[1] = 16'(b1); p.qb[2] = 16'(b2); p.qb[3] = 16'(b3);
    p.blend = 17'(t);
    return p;
  endfunction

  initial begin
    pair_t       p;
    logic [12:0] tols [4];
    tols = '{13'd4, 13'd0, 13'd4096, 13'd37};
    rst_n    = 1'b0;
    calm     = 1'b0;
    hold_req = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_ch.valid    = 1'b0;
    in_ch.first_x  = '0;
    in_ch.first_y  = '0;
    in_ch.first_z  = '0;
    in_ch.first_w  = '0;
    in_ch.second_x = '0;
    in_ch.second_y = '0;
    in_ch.second_z = '0;
    in_ch.second_w = '0;
    in_ch.blend    = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    read_tol();

    // Directed items: blend edges, flipped arcs, parallel and oversized inputs.
    offer_pair(make_pair(32767, 0, 0, 0, 0, 32767, 0, 0, 0));
    offer_pair(make_pair(32767, 0, 0, 0, 0, 32767, 0, 0, 65536));
    offer_pair(make_pair(32767, 0, 0, 0, 0, 32767, 0, 0, 131071));
    offer_pair(make_pair(32767, 0, 0, 0, 0, 32767, 0, 0, 4));
    offer_pair(make_pair(32767, 0, 0, 0, 0, 32767, 0, 0, 5));
    offer_pair(make_pair(32767, 0, 0, 0, 0, 32767, 0, 0, 65532));
    offer_pair(make_pair(32767, 0, 0, 0, 0, 32767, 0, 0, 65531));
    offer_pair(make_pair(32767, 0, 0, 0, 0, 32767, 0, 0, 32768));
    offer_pair(make_pair(0, 0, 0, 32767, 0, 0, 0, 32767, 20000));
    offer_pair(make_pair(0, 0, 0, 32767, 0, 0, 0, -32767, 20000));
    offer_pair(make_pair(0, 0, 23170, 23170, 0, 0, -23170, -23170, 30000));
    offer_pair(make_pair(23170, 0, 0, 23170, 0, -23170, 0, -23170, 45000));
    offer_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                         10000));
    offer_pair(make_pair(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767,
                         10000));
    offer_pair(make_pair(32767, 32767, 0, 0, 32767, 0, 32767, 0, 50000));
    offer_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 30000));
    offer_pair(make_pair(32767, 0, 0, 0, 32700, 2000, 0, 0, 40000));
    offer_pair(make_pair(32767, 0, 0, 0, 32767, 0, 0, 8, 40000));
    offer_pair(make_pair(0, 32767, 0, 0, 0, 0, 32767, 0, 1));

    // Phases at several tolerances, with random items in each.
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_tol(tols[ph]);
      read_tol();
      for (int n = 0; n < 345; n++) begin
        calm = (ph == 3 && n < 200);
        if (ph == 1 && n == 100) hold_req = 1'b1;
        if (ph == 1 && n == 110) hold_req = 1'b0;
        if (ph == 2 && n == 150) drain();
        p = random_pair();
        offer_pair(p);
      end
    end
    calm = 1'b0;
    drain();

    if (sb.errors == 0 && sb.predicted.size() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule

// File: filelist.f
sv/qslerp_pkg.sv
sv/qslerp_if.sv
sv/qslerp_isqrt.sv
sv/qslerp_vec.sv
sv/qslerp_sin3.sv
sv/qslerp_div.sv
sv/quaternion_slerp.sv
tb/sv/testbench.sv
